// ===== src/asie_pkg.sv =====
package asie_pkg;

    typedef enum logic [1:0] {
        ACT_MEM_WR = 2'd0,
        ACT_MEM_RD = 2'd1,
        ACT_REG_RD = 2'd2,
        ACT_EXEC   = 2'd3
    } t_action;

    // Which register operand a register file read fetches.
    typedef enum logic [2:0] {
        RK_RM,
        RK_RS,
        RK_RN,
        RK_RD,
        RK_HOST
    } t_rkind;

    typedef enum logic [2:0] {
        GPIO_NONE   = 3'd0,
        GPIO_PINS0  = 3'd1,
        GPIO_PINS10 = 3'd2,
        GPIO_PINS20 = 3'd3,
        GPIO_ON     = 3'd4,
        GPIO_OFF    = 3'd5
    } t_gpio;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_HREAD_W,
        S_HREG_W,
        S_FETCH_W,
        S_DECODE,
        S_RD_RS,
        S_RD_RN,
        S_RD_RD,
        S_RD_WAIT,
        S_SHIFT,
        S_EXEC,
        S_XFER,
        S_LOAD_W,
        S_POST_WB,
        S_FINISH,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic   clr;
        logic   ready;
        logic   host_wr;
        logic   host_rd;
        logic   host_rcap;
        logic   fetch;
        logic   cap_instr;
        logic   reg_rd;
        t_rkind rkind;
        logic   set_halt;
        logic   shift;
        logic   exec;
        logic   xfer;
        logic   load_wb;
        logic   post_wb;
        logic   finish;
        logic   emit;
    } t_cmd;

    typedef struct packed {
        logic    clr_last;
        t_action action;
        logic    halted;
        logic    pc_oob;
        logic    instr_zero;
        logic    cond_pass;
        logic    is_xfer;
        logic    xfer_mem_load;
        logic    post_index;
    } t_stat;

    typedef struct packed {
        logic        berr;
        t_gpio       gpio;
        logic        done;
        logic        halted;
        logic [31:0] rdata;
    } t_res;

    localparam logic [31:0] GPIO_ADDR_PINS0  = 32'h2020_0000;
    localparam logic [31:0] GPIO_ADDR_PINS10 = 32'h2020_0004;
    localparam logic [31:0] GPIO_ADDR_PINS20 = 32'h2020_0008;
    localparam logic [31:0] GPIO_ADDR_ON     = 32'h2020_001c;
    localparam logic [31:0] GPIO_ADDR_OFF    = 32'h2020_0028;

    localparam logic [3:0] DP_AND = 4'd0;
    localparam logic [3:0] DP_EOR = 4'd1;
    localparam logic [3:0] DP_SUB = 4'd2;
    localparam logic [3:0] DP_RSB = 4'd3;
    localparam logic [3:0] DP_ADD = 4'd4;
    localparam logic [3:0] DP_TST = 4'd8;
    localparam logic [3:0] DP_TEQ = 4'd9;
    localparam logic [3:0] DP_CMP = 4'd10;
    localparam logic [3:0] DP_ORR = 4'd12;
    localparam logic [3:0] DP_MOV = 4'd13;

    localparam logic [3:0] CC_EQ = 4'd0;
    localparam logic [3:0] CC_NE = 4'd1;
    localparam logic [3:0] CC_GE = 4'd10;
    localparam logic [3:0] CC_LT = 4'd11;
    localparam logic [3:0] CC_GT = 4'd12;
    localparam logic [3:0] CC_LE = 4'd13;
    localparam logic [3:0] CC_AL = 4'd14;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam int FL_N = 3;
    localparam int FL_Z = 2;
    localparam int FL_C = 1;
    localparam int FL_V = 0;

endpackage

// ===== src/asie_ram.sv =====
module asie_ram #(
    parameter int W = 8,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;
endmodule

// ===== src/asie_ctrl.sv =====
module asie_ctrl
    import asie_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_acc,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rkind = RK_RM;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_in_acc) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (i_stat.action)
                    ACT_MEM_WR: begin
                        o_cmd.host_wr = 1'b1;
                        n_state = S_RESULT;
                    end
                    ACT_MEM_RD: begin
                        o_cmd.host_rd = 1'b1;
                        n_state = S_HREAD_W;
                    end
                    ACT_REG_RD: begin
                        o_cmd.reg_rd = 1'b1;
                        o_cmd.rkind  = RK_HOST;
                        n_state = S_HREG_W;
                    end
                    default: begin
                        if (i_stat.halted) begin
                            n_state = S_RESULT;
                        end else if (i_stat.pc_oob) begin
                            o_cmd.set_halt = 1'b1;
                            n_state = S_RESULT;
                        end else begin
                            o_cmd.fetch = 1'b1;
                            n_state = S_FETCH_W;
                        end
                    end
                endcase
            end
            S_HREAD_W: begin
                o_cmd.host_rcap = 1'b1;
                n_state = S_RESULT;
            end
            S_HREG_W:  n_state = S_RESULT;
            S_FETCH_W: begin
                o_cmd.cap_instr = 1'b1;
                n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.instr_zero) begin
                    o_cmd.set_halt = 1'b1;
                    n_state = S_RESULT;
                end else if (!i_stat.cond_pass) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.reg_rd = 1'b1;
                    o_cmd.rkind  = RK_RM;
                    n_state = S_RD_RS;
                end
            end
            S_RD_RS: begin
                o_cmd.reg_rd = 1'b1;
                o_cmd.rkind  = RK_RS;
                n_state = S_RD_RN;
            end
            S_RD_RN: begin
                o_cmd.reg_rd = 1'b1;
                o_cmd.rkind  = RK_RN;
                n_state = S_RD_RD;
            end
            S_RD_RD: begin
                o_cmd.reg_rd = 1'b1;
                o_cmd.rkind  = RK_RD;
                n_state = S_RD_WAIT;
            end
            S_RD_WAIT: n_state = S_SHIFT;
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_stat.is_xfer ? S_XFER : S_FINISH;
            end
            S_XFER: begin
                o_cmd.xfer = 1'b1;
                if (i_stat.xfer_mem_load) begin
                    n_state = S_LOAD_W;
                end else if (i_stat.post_index) begin
                    n_state = S_POST_WB;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_LOAD_W: begin
                o_cmd.load_wb = 1'b1;
                n_state = i_stat.post_index ? S_POST_WB : S_FINISH;
            end
            S_POST_WB: begin
                o_cmd.post_wb = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule

// ===== src/asie_dp.sv =====
module asie_dp
    import asie_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_acc,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic [3:0]  i_reg_select,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output t_res        o_res
);
    localparam int AW   = $clog2(MEM_BYTES);
    localparam int RW   = AW - 2;
    localparam int ROWS = MEM_BYTES / 4;
    localparam logic [31:0] MEM_LAST = 32'(MEM_BYTES - 4);

    // Item and architectural state.
    t_action     r_action;
    logic [15:0] r_addr;
    logic [31:0] r_wdata;
    logic [3:0]  r_sel;
    logic [31:0] r_pc;
    logic [3:0]  r_flags;
    logic        r_halt;
    logic        r_pcw;
    logic [31:0] r_instr;
    logic [31:0] r_rm, r_rs, r_rn, r_rd;
    logic [31:0] r_op2;
    logic        r_shc;
    logic [31:0] r_prod;
    logic [31:0] r_xaddr, r_moved;
    logic        r_done;
    t_gpio       r_gpio;
    logic        r_berr;
    logic [31:0] r_rdata;
    logic [RW-1:0] r_clr;
    logic        r_rpend;
    t_rkind      r_rkind;
    logic [3:0]  r_ridx;
    logic [1:0]  r_rlo;

    // Decode.
    logic is_br, is_xf, is_dp, is_mul, cin;
    assign is_br  = r_instr[27];
    assign is_xf  = !r_instr[27] && r_instr[26];
    assign is_dp  = !r_instr[27] && !r_instr[26]
                    && (r_instr[25] || !r_instr[4] || !r_instr[7]);
    assign is_mul = !is_br && !is_xf && !is_dp;
    assign cin    = r_flags[FL_C];

    logic cond_ok;
    always_comb begin
        unique case (r_instr[31:28])
            CC_EQ:   cond_ok = r_flags[FL_Z];
            CC_NE:   cond_ok = !r_flags[FL_Z];
            CC_GE:   cond_ok = r_flags[FL_N] == r_flags[FL_V];
            CC_LT:   cond_ok = r_flags[FL_N] != r_flags[FL_V];
            CC_GT:   cond_ok = !r_flags[FL_Z] && (r_flags[FL_N] == r_flags[FL_V]);
            CC_LE:   cond_ok = r_flags[FL_Z] || (r_flags[FL_N] != r_flags[FL_V]);
            CC_AL:   cond_ok = 1'b1;
            default: cond_ok = 1'b0;
        endcase
    end

    // Barrel shifter for register operands.
    logic [11:0] sf;
    logic [1:0]  styp;
    logic [7:0]  samt;
    logic [32:0] t_lsl, t_lsr, t_asr;
    logic [63:0] t_ror, t_imm;
    logic [31:0] sh_r, imm_r;
    logic        sh_c, imm_c;
    logic [4:0]  imm_rot;

    assign sf    = r_instr[11:0];
    assign styp  = sf[6:5];
    assign samt  = sf[4] ? r_rs[7:0] : ((sf[11:7] == 5'd0) ? 8'd32 : {3'b000, sf[11:7]});
    assign t_lsl = {1'b0, r_rm} << samt[4:0];
    assign t_lsr = {r_rm, 1'b0} >> samt[4:0];
    assign t_asr = 33'($signed({r_rm, 1'b0}) >>> samt[4:0]);
    assign t_ror = {r_rm, r_rm} >> samt[4:0];

    always_comb begin
        sh_r = r_rm;
        sh_c = cin;
        if (sf[4] && r_rs[7:0] == 8'd0) begin
            sh_r = r_rm;
        end else if (!sf[4] && sf[11:7] == 5'd0 && styp == SH_LSL) begin
            sh_r = r_rm;
        end else if (!sf[4] && sf[11:7] == 5'd0 && styp == SH_ROR) begin
            // Rotate right extended through the carry.
            sh_r = {cin, r_rm[31:1]};
            sh_c = r_rm[0];
        end else begin
            unique case (styp)
                SH_LSL: begin
                    if (samt < 8'd32) begin
                        sh_r = t_lsl[31:0];
                        sh_c = t_lsl[32];
                    end else begin
                        sh_r = 32'd0;
                        sh_c = (samt == 8'd32) ? r_rm[0] : 1'b0;
                    end
                end
                SH_LSR: begin
                    if (samt < 8'd32) begin
                        sh_r = t_lsr[32:1];
                        sh_c = t_lsr[0];
                    end else begin
                        sh_r = 32'd0;
                        sh_c = (samt == 8'd32) ? r_rm[31] : 1'b0;
                    end
                end
                SH_ASR: begin
                    if (samt >= 8'd32) begin
                        sh_r = {32{r_rm[31]}};
                        sh_c = r_rm[31];
                    end else begin
                        sh_r = t_asr[32:1];
                        sh_c = t_asr[0];
                    end
                end
                default: begin
                    sh_r = t_ror[31:0];
                    sh_c = t_ror[31];
                end
            endcase
        end
    end

    assign imm_rot = {r_instr[11:8], 1'b0};
    assign t_imm   = {24'd0, r_instr[7:0], 24'd0, r_instr[7:0]} >> imm_rot;
    assign imm_r   = t_imm[31:0];
    assign imm_c   = (imm_rot != 5'd0) ? imm_r[31] : cin;

    logic [31:0] w_prod;
    assign w_prod = r_rm * r_rs;

    // ALU.
    logic [3:0]  dp_op;
    logic [31:0] alu_r;
    logic [32:0] add_s;
    logic        alu_c, alu_ok, alu_keep;
    assign dp_op = r_instr[24:21];
    assign add_s = {1'b0, r_rn} + {1'b0, r_op2};

    always_comb begin
        alu_r    = 32'd0;
        alu_c    = r_shc;
        alu_ok   = 1'b1;
        alu_keep = 1'b1;
        unique case (dp_op)
            DP_AND, DP_TST: begin
                alu_r    = r_rn & r_op2;
                alu_keep = (dp_op == DP_AND);
            end
            DP_EOR, DP_TEQ: begin
                alu_r    = r_rn ^ r_op2;
                alu_keep = (dp_op == DP_EOR);
            end
            DP_SUB, DP_CMP: begin
                alu_r    = r_rn - r_op2;
                alu_c    = r_rn >= r_op2;
                alu_keep = (dp_op == DP_SUB);
            end
            DP_RSB: begin
                alu_r = r_op2 - r_rn;
                alu_c = r_op2 >= r_rn;
            end
            DP_ADD: begin
                alu_r = add_s[31:0];
                alu_c = add_s[32];
            end
            DP_ORR: alu_r = r_rn | r_op2;
            DP_MOV: alu_r = r_op2;
            default: begin
                alu_ok   = 1'b0;
                alu_keep = 1'b0;
            end
        endcase
    end

    logic [31:0] mul_r, br_tgt, x_moved, x_addr;
    assign mul_r   = r_instr[21] ? (r_prod + r_rd) : r_prod;
    assign br_tgt  = r_pc + 32'd8 + {{6{r_instr[23]}}, r_instr[23:0], 2'b00};
    assign x_moved = r_instr[23] ? (r_rn + r_op2) : (r_rn - r_op2);
    assign x_addr  = r_instr[24] ? x_moved : r_rn;

    // Transfer classification.
    logic  x_load, x_oob, x_mem_ok;
    t_gpio x_gpio;
    assign x_load = r_instr[20];
    assign x_oob  = r_xaddr > MEM_LAST;
    always_comb begin
        if (r_xaddr == GPIO_ADDR_PINS0)               x_gpio = GPIO_PINS0;
        else if (r_xaddr == GPIO_ADDR_PINS10)         x_gpio = GPIO_PINS10;
        else if (r_xaddr == GPIO_ADDR_PINS20)         x_gpio = GPIO_PINS20;
        else if (!x_load && r_xaddr == GPIO_ADDR_ON)  x_gpio = GPIO_ON;
        else if (!x_load && r_xaddr == GPIO_ADDR_OFF) x_gpio = GPIO_OFF;
        else                                          x_gpio = GPIO_NONE;
    end
    assign x_mem_ok = (x_gpio == GPIO_NONE) && !x_oob;

    // Byte memory: four banks so that any unaligned word is one access.
    logic [AW-1:0] w_maddr;
    logic [31:0]   w_mwdata, w_mword;
    logic          w_mwe, w_mre;
    logic [7:0]    w_bq [4];

    always_comb begin
        w_maddr  = r_pc[AW-1:0];
        w_mwdata = r_rd;
        w_mwe    = 1'b0;
        w_mre    = 1'b0;
        if (i_cmd.host_wr || i_cmd.host_rd) begin
            w_maddr  = AW'({16'd0, r_addr});
            w_mwdata = r_wdata;
            w_mwe    = i_cmd.host_wr;
            w_mre    = i_cmd.host_rd;
        end else if (i_cmd.fetch) begin
            w_mre = 1'b1;
        end else if (i_cmd.xfer) begin
            w_maddr = r_xaddr[AW-1:0];
            w_mwe   = x_mem_ok && !x_load;
            w_mre   = x_mem_ok && x_load;
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [1:0]    w_i;
        logic [AW-1:0] w_sum;
        logic [RW-1:0] w_row;
        logic [7:0]    w_bd;
        assign w_i   = 2'(b) - w_maddr[1:0];
        assign w_sum = w_maddr + AW'(w_i);
        assign w_row = i_cmd.clr ? r_clr : w_sum[AW-1:2];
        assign w_bd  = i_cmd.clr ? 8'h00 : 8'(w_mwdata >> {w_i, 3'b000});
        asie_ram #(.W(8), .D(ROWS)) u_bank (
            .i_clk  (i_clk),
            .i_we   (i_cmd.clr || w_mwe),
            .i_re   (w_mre),
            .i_addr (w_row),
            .i_wdata(w_bd),
            .o_rdata(w_bq[b])
        );
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_mword[8*i +: 8] = w_bq[2'(r_rlo + 2'(i))];
        end
    end

    // Register file r0..r14; r15 lives in r_pc.
    logic [3:0]  w_rf_ridx, w_widx;
    logic [31:0] w_wval, w_rf_q;
    logic        w_we, w_rf_we, w_clr_rf;

    always_comb begin
        unique case (i_cmd.rkind)
            RK_RM:   w_rf_ridx = r_instr[3:0];
            RK_RS:   w_rf_ridx = r_instr[11:8];
            RK_RN:   w_rf_ridx = r_instr[19:16];
            RK_RD:   w_rf_ridx = r_instr[15:12];
            RK_HOST: w_rf_ridx = r_sel;
            default: w_rf_ridx = r_sel;
        endcase
    end

    always_comb begin
        w_we   = 1'b0;
        w_widx = r_instr[15:12];
        w_wval = alu_r;
        if (i_cmd.exec) begin
            if (is_br) begin
                w_we   = 1'b1;
                w_widx = 4'hf;
                w_wval = br_tgt;
            end else if (is_dp) begin
                w_we = alu_ok && alu_keep;
            end else if (is_mul) begin
                w_we   = 1'b1;
                w_widx = r_instr[19:16];
                w_wval = mul_r;
            end
        end else if (i_cmd.xfer) begin
            w_we   = x_load && (x_gpio != GPIO_NONE);
            w_wval = r_xaddr;
        end else if (i_cmd.load_wb) begin
            w_we   = 1'b1;
            w_wval = w_mword;
        end else if (i_cmd.post_wb) begin
            w_we   = 1'b1;
            w_widx = r_instr[19:16];
            w_wval = r_moved;
        end
    end

    assign w_clr_rf = i_cmd.clr && (r_clr[RW-1:4] == '0);
    assign w_rf_we  = w_clr_rf || (w_we && w_widx != 4'hf);

    asie_ram #(.W(32), .D(16)) u_rf (
        .i_clk  (i_clk),
        .i_we   (w_rf_we),
        .i_re   (i_cmd.reg_rd),
        .i_addr (w_rf_we ? (w_clr_rf ? r_clr[3:0] : w_widx) : w_rf_ridx),
        .i_wdata(w_clr_rf ? 32'd0 : w_wval),
        .o_rdata(w_rf_q)
    );

    logic [31:0] w_opnd;
    assign w_opnd = (r_ridx != 4'hf) ? w_rf_q
                  : ((r_rkind == RK_HOST) ? r_pc : r_pc + 32'd8);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_pc    <= 32'd0;
            r_flags <= 4'd0;
            r_halt  <= 1'b0;
            r_rpend <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            r_rpend <= i_cmd.reg_rd;
            if (i_cmd.set_halt) r_halt <= 1'b1;
            if (w_we && w_widx == 4'hf) begin
                r_pc <= w_wval;
            end else if (i_cmd.finish && !r_pcw) begin
                r_pc <= r_pc + 32'd4;
            end
            if (i_cmd.exec && is_dp && alu_ok && r_instr[20]) begin
                r_flags[FL_N] <= alu_r[31];
                r_flags[FL_Z] <= alu_r == 32'd0;
                r_flags[FL_C] <= alu_c;
            end else if (i_cmd.exec && is_mul && r_instr[20]) begin
                r_flags[FL_N] <= mul_r[31];
                r_flags[FL_Z] <= mul_r == 32'd0;
            end
        end
    end

    // Datapath payload.
    always_ff @(posedge i_clk) begin
        if (i_in_acc) begin
            r_action <= t_action'(i_action);
            r_addr   <= i_address;
            r_wdata  <= i_write_data;
            r_sel    <= i_reg_select;
            r_pcw    <= 1'b0;
            r_done   <= 1'b0;
            r_gpio   <= GPIO_NONE;
            r_berr   <= 1'b0;
            r_rdata  <= 32'd0;
        end
        if (w_we && w_widx == 4'hf) r_pcw <= 1'b1;
        if (w_mre) r_rlo <= w_maddr[1:0];
        if (i_cmd.reg_rd) begin
            r_rkind <= i_cmd.rkind;
            r_ridx  <= w_rf_ridx;
        end
        if (r_rpend) begin
            unique case (r_rkind)
                RK_RM:   r_rm    <= w_opnd;
                RK_RS:   r_rs    <= w_opnd;
                RK_RN:   r_rn    <= w_opnd;
                RK_RD:   r_rd    <= w_opnd;
                default: r_rdata <= w_opnd;
            endcase
        end
        if (i_cmd.host_rcap) r_rdata <= w_mword;
        if (i_cmd.cap_instr) r_instr <= w_mword;
        if (i_cmd.shift) begin
            if ((is_dp && r_instr[25]) || (is_xf && !r_instr[25])) begin
                r_op2 <= is_dp ? imm_r : {20'd0, r_instr[11:0]};
                r_shc <= imm_c;
            end else begin
                r_op2 <= sh_r;
                r_shc <= sh_c;
            end
            r_prod <= w_prod;
        end
        if (i_cmd.exec) begin
            r_done  <= is_dp ? alu_ok : 1'b1;
            r_xaddr <= x_addr;
            r_moved <= x_moved;
        end
        if (i_cmd.xfer) begin
            r_gpio <= x_gpio;
            r_berr <= (x_gpio == GPIO_NONE) && x_oob;
        end
    end

    assign o_stat.clr_last      = r_clr == RW'(ROWS - 1);
    assign o_stat.action        = r_action;
    assign o_stat.halted        = r_halt;
    assign o_stat.pc_oob        = r_pc > MEM_LAST;
    assign o_stat.instr_zero    = r_instr == 32'd0;
    assign o_stat.cond_pass     = cond_ok;
    assign o_stat.is_xfer       = is_xf;
    assign o_stat.xfer_mem_load = x_load && x_mem_ok;
    assign o_stat.post_index    = !r_instr[24];

    assign o_res.rdata  = (r_action == ACT_EXEC) ? r_pc : r_rdata;
    assign o_res.halted = r_halt;
    assign o_res.done   = r_done;
    assign o_res.gpio   = r_gpio;
    assign o_res.berr   = r_berr;
endmodule

// ===== src/arm_subset_instruction_executor.sv =====
// Executor for a subset of the ARM instruction set with its own byte memory of
// MEM_BYTES bytes (a power of two), registers r0..r15 and the N, Z, C, V flags.
// Each input item writes or reads a little-endian memory word, reads a register,
// or executes the instruction at the PC; every item yields exactly one result.
// After reset the block clears its memory, one row of four bytes per cycle, and
// takes no item until the clear is done. Items are handled one at a time; an
// executed instruction is paced by the single-port register file that hands over
// one operand per cycle and by the registered memory read of the fetch and of a
// load, while a failed condition or a halt skips the operand reads. A result
// waits in the output register while the next item is already accepted.
module arm_subset_instruction_executor
    import asie_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], address[17:2], write_data[49:18], reg_select[53:50]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[31:0], halted[32], executed[33], gpio_event[36:34],
    // bounds_error[37]
    output logic [39:0] m_axis_tdata
);
    t_cmd  w_cmd;
    t_stat w_stat;
    t_res  w_res;
    logic  w_in_acc, w_out_free;

    logic        r_m_tvalid;
    logic [39:0] r_m_tdata;

    assign s_axis_tready = w_cmd.ready;
    assign w_in_acc      = s_axis_tvalid && w_cmd.ready;
    // The output register can be loaded when empty or being drained.
    assign w_out_free    = !r_m_tvalid || m_axis_tready;

    asie_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_acc  (w_in_acc),
        .i_out_free(w_out_free),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    asie_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_acc    (w_in_acc),
        .i_action    (s_axis_tdata[1:0]),
        .i_address   (s_axis_tdata[17:2]),
        .i_write_data(s_axis_tdata[49:18]),
        .i_reg_select(s_axis_tdata[53:50]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_m_tdata <= {2'b00, w_res.berr, w_res.gpio, w_res.done, w_res.halted,
                          w_res.rdata};
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import asie_pkg::*;

    localparam int MEM_SZ = 65536;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // action[1:0], address[17:2], write_data[49:18], reg_select[53:50]
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // read_data[31:0], halted[32], executed[33], gpio_event[36:34],
    // bounds_error[37]
    logic [39:0] m_axis_tdata;

    arm_subset_instruction_executor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state: a shadow copy of the memory, registers, flags and halt mark.
    logic [7:0]  shadow_mem [MEM_SZ];
    logic [31:0] shadow_regs [16];
    logic [3:0]  shadow_flags;
    logic        shadow_halt;
    logic [31:0] exec_pc;
    logic        pc_touched;

    // Expected results in order of acceptance.
    t_res expected_q [$];

    int  n_fail;
    int  n_items;
    int  n_results;
    int  n_executed;
    bit  hold_off;

    function automatic logic [31:0] mem_word(input logic [31:0] a);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < 4; i++) v[8*i +: 8] = shadow_mem[(a + i) % MEM_SZ];
        return v;
    endfunction

    function automatic void mem_store(input logic [31:0] a, input logic [31:0] v);
        for (int i = 0; i < 4; i++) shadow_mem[(a + i) % MEM_SZ] = v[8*i +: 8];
    endfunction

    function automatic logic [31:0] reg_get(input logic [3:0] n);
        return (n == 4'd15) ? exec_pc + 32'd8 : shadow_regs[n];
    endfunction

    function automatic void reg_put(input logic [3:0] n, input logic [31:0] v);
        if (n == 4'd15) pc_touched = 1'b1;
        shadow_regs[n] = v;
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] v, input int a);
        a = a & 31;
        if (a == 0) return v;
        return (v >> a) | (v << (32 - a));
    endfunction

    // Barrel shift for a nonzero amount, with carry out.
    function automatic logic [31:0] barrel(input logic [31:0] v, input logic [1:0] kind,
                                           input int amt, inout logic c);
        logic sgn;
        sgn = v[31];
        case (kind)
            SH_LSL: begin
                if (amt < 32) begin
                    c = v[32 - amt];
                    return v << amt;
                end
                c = (amt == 32) ? v[0] : 1'b0;
                return '0;
            end
            SH_LSR: begin
                if (amt < 32) begin
                    c = v[amt - 1];
                    return v >> amt;
                end
                c = (amt == 32) ? sgn : 1'b0;
                return '0;
            end
            SH_ASR: begin
                if (amt >= 32) begin
                    c = sgn;
                    return {32{sgn}};
                end
                c = v[amt - 1];
                return $unsigned($signed(v) >>> amt);
            end
            default: begin
                if ((amt & 31) == 0) begin
                    c = sgn;
                    return v;
                end
                c = v[(amt & 31) - 1];
                return ror32(v, amt);
            end
        endcase
    endfunction

    function automatic logic [31:0] reg_operand(input logic [11:0] f, inout logic c);
        logic [31:0] v;
        logic [1:0]  kind;
        int          amt;
        logic [31:0] r;
        v = reg_get(f[3:0]);
        kind = f[6:5];
        if (f[4]) begin
            amt = reg_get(f[11:8]) & 32'hff;
            if (amt == 0) return v;
            return barrel(v, kind, amt, c);
        end
        amt = f[11:7];
        if (amt == 0) begin
            if (kind == SH_LSL) return v;
            if (kind == SH_ROR) begin
                r = {c, v[31:1]};
                c = v[0];
                return r;
            end
            amt = 32;
        end
        return barrel(v, kind, amt, c);
    endfunction

    function automatic logic cond_ok(input logic [3:0] cc);
        logic n, z, v;
        n = shadow_flags[FL_N];
        z = shadow_flags[FL_Z];
        v = shadow_flags[FL_V];
        case (cc)
            CC_EQ: return z;
            CC_NE: return !z;
            CC_GE: return n == v;
            CC_LT: return n != v;
            CC_GT: return !z && n == v;
            CC_LE: return z || n != v;
            CC_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void flags_update(input logic [31:0] r, input logic c,
                                         input logic with_c);
        shadow_flags[FL_Z] = (r == 0);
        shadow_flags[FL_N] = r[31];
        if (with_c) shadow_flags[FL_C] = c;
    endfunction

    function automatic t_gpio gpio_of(input logic [31:0] a, input logic is_store);
        if (a == GPIO_ADDR_PINS0) return GPIO_PINS0;
        if (a == GPIO_ADDR_PINS10) return GPIO_PINS10;
        if (a == GPIO_ADDR_PINS20) return GPIO_PINS20;
        if (is_store && a == GPIO_ADDR_ON) return GPIO_ON;
        if (is_store && a == GPIO_ADDR_OFF) return GPIO_OFF;
        return GPIO_NONE;
    endfunction

    function automatic void load_store(input logic [31:0] w, inout t_res res);
        logic        c;
        logic [31:0] off, base, moved, addr;
        logic        is_load;
        t_gpio       g;
        c = shadow_flags[FL_C];
        off = w[25] ? reg_operand(w[11:0], c) : {20'd0, w[11:0]};
        base = reg_get(w[19:16]);
        moved = w[23] ? base + off : base - off;
        addr = w[24] ? moved : base;
        is_load = w[20];
        g = gpio_of(addr, !is_load);
        if (g != GPIO_NONE) begin
            res.gpio = g;
            if (is_load) reg_put(w[15:12], addr);
        end else if (addr > MEM_SZ - 4) begin
            res.berr = 1'b1;
        end else if (is_load) begin
            reg_put(w[15:12], mem_word(addr));
        end else begin
            mem_store(addr, reg_get(w[15:12]));
        end
        if (!w[24]) reg_put(w[19:16], moved);
    endfunction

    function automatic logic alu_op(input logic [31:0] w);
        logic [3:0]  op;
        logic        c;
        logic [31:0] op2, a, r;
        int          rot;
        logic        keep;
        op = w[24:21];
        c = shadow_flags[FL_C];
        keep = 1'b1;
        if (w[25]) begin
            rot = w[11:8] * 2;
            op2 = ror32({24'd0, w[7:0]}, rot);
            if (rot != 0) c = op2[31];
        end else begin
            op2 = reg_operand(w[11:0], c);
        end
        a = reg_get(w[19:16]);
        case (op)
            DP_AND, DP_TST: begin r = a & op2; keep = (op == DP_AND); end
            DP_EOR, DP_TEQ: begin r = a ^ op2; keep = (op == DP_EOR); end
            DP_SUB, DP_CMP: begin r = a - op2; c = a >= op2; keep = (op == DP_SUB); end
            DP_RSB: begin r = op2 - a; c = op2 >= a; end
            DP_ADD: begin r = a + op2; c = r < a; end
            DP_ORR: r = a | op2;
            DP_MOV: r = op2;
            default: return 1'b0;
        endcase
        if (w[20]) flags_update(r, c, 1'b1);
        if (keep) reg_put(w[15:12], r);
        return 1'b1;
    endfunction

    function automatic void run_instruction(inout t_res res);
        logic [31:0] w, boff, prod;
        exec_pc = shadow_regs[15];
        if (exec_pc > MEM_SZ - 4) begin
            shadow_halt = 1'b1;
            return;
        end
        w = mem_word(exec_pc);
        if (w == 0) begin
            shadow_halt = 1'b1;
            return;
        end
        pc_touched = 1'b0;
        if (cond_ok(w[31:28])) begin
            res.done = 1'b1;
            if (w[27]) begin
                boff = ({8'd0, w[23:0]} << 2) & 32'h03ff_ffff;
                if (w[23]) boff = boff + 32'hfc00_0000;
                reg_put(4'd15, exec_pc + 32'd8 + boff);
            end else if (w[26]) begin
                load_store(w, res);
            end else if (w[25] || !w[4] || !w[7]) begin
                res.done = alu_op(w);
            end else begin
                prod = reg_get(w[3:0]) * reg_get(w[11:8]);
                if (w[21]) prod = prod + reg_get(w[15:12]);
                if (w[20]) flags_update(prod, 1'b0, 1'b0);
                reg_put(w[19:16], prod);
            end
        end
        if (!pc_touched) shadow_regs[15] = exec_pc + 32'd4;
    endfunction

    function automatic t_res predict_item(input t_action act, input logic [15:0] addr,
                                          input logic [31:0] wdata, input logic [3:0] sel);
        t_res res;
        res = '0;
        res.gpio = GPIO_NONE;
        case (act)
            ACT_MEM_WR: mem_store(addr, wdata);
            ACT_MEM_RD: res.rdata = mem_word(addr);
            ACT_REG_RD: res.rdata = shadow_regs[sel];
            default: begin
                if (!shadow_halt) run_instruction(res);
                res.rdata = shadow_regs[15];
            end
        endcase
        res.halted = shadow_halt;
        return res;
    endfunction

    // Sends one item once the handshake completes, after a random gap.
    // With no gap the next item follows straight on; tvalid drops only for a gap.
    task automatic send_item(input t_action act, input logic [15:0] addr,
                             input logic [31:0] wdata, input logic [3:0] sel);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, sel, wdata, addr, act};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // Prediction runs at acceptance, so items are modeled in order.
        expected_q.push_back(predict_item(act, addr, wdata, sel));
        if (act == ACT_EXEC) n_executed++;
        n_items++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_word(input logic [15:0] a, input logic [31:0] w);
        send_item(ACT_MEM_WR, a, w, 4'($urandom));
    endtask

    task automatic exec_one();
        send_item(ACT_EXEC, 16'($urandom), 32'($urandom), 4'($urandom));
    endtask

    // Rewinds the PC to zero with a branch placed at the current PC.
    task automatic rewind_pc();
        logic [31:0] pc, offs;
        pc = shadow_regs[15];
        if (shadow_halt || pc > MEM_SZ - 4) return;
        offs = (32'd0 - pc - 32'd8) >> 2;
        load_word(pc[15:0], {CC_AL, 4'b1010, offs[23:0]});
        exec_one();
    endtask

    function automatic logic [31:0] rand_dp();
        logic [31:0] w;
        logic [3:0]  ops [10];
        ops = '{DP_AND, DP_EOR, DP_SUB, DP_RSB, DP_ADD, DP_TST, DP_TEQ, DP_CMP,
                DP_ORR, DP_MOV};
        w = $urandom;
        w[27:26] = 2'b00;
        w[31:28] = ($urandom_range(0, 2) == 0) ? 4'($urandom) : CC_AL;
        if ($urandom_range(0, 9) != 0) w[24:21] = ops[$urandom_range(0, 9)];
        if (!w[25] && w[4]) w[7] = 1'b0;
        // Keep the PC out of most destinations so programs run on.
        if ($urandom_range(0, 7) != 0 && w[15:12] == 4'd15) w[15:12] = 4'd3;
        return w;
    endfunction

    function automatic logic [31:0] rand_mul();
        logic [31:0] w;
        w = $urandom;
        w[31:28] = ($urandom_range(0, 3) == 0) ? 4'($urandom) : CC_AL;
        w[27:22] = 6'd0;
        w[7:4] = 4'b1001;
        if (w[19:16] == 4'd15) w[19:16] = 4'd5;
        return w;
    endfunction

    function automatic logic [31:0] rand_xfer();
        logic [31:0] w;
        w = $urandom;
        w[31:28] = ($urandom_range(0, 3) == 0) ? 4'($urandom) : CC_AL;
        w[27:26] = 2'b01;
        if (w[25]) w[4] = 1'b0;
        if (w[19:16] == 4'd15 || w[15:12] == 4'd15) begin
            w[19:16] = 4'd8;
            w[15:12] = 4'd9;
        end
        return w;
    endfunction

    task automatic random_program(input int n_instr);
        logic [31:0] w;
        logic [31:0] pc;
        int          k;
        for (int i = 0; i < n_instr; i++) begin
            pc = shadow_regs[15];
            if (shadow_halt || pc > MEM_SZ - 4) return;
            k = $urandom_range(0, 19);
            if (k < 9) w = rand_dp();
            else if (k < 12) w = rand_mul();
            else if (k < 17) w = rand_xfer();
            else if (k < 19) begin
                w = {4'($urandom), 4'b1010, 24'($urandom_range(0, 40))};
                if ($urandom_range(0, 1)) w[23:0] = 24'hffffff - 24'($urandom_range(0, 10));
            end else w = $urandom;
            if (w == 0) w = 32'h1;
            load_word(pc[15:0], w);
            exec_one();
        end
    endtask

    task automatic seed_regs();
        logic [31:0] v;
        logic [31:0] pc;
        // Base registers r8 and r10 get GPIO addresses, addresses near the top of memory or small addresses.
        for (int r = 0; r < 13; r++) begin
            v = $urandom;
            if (r == 8 || r == 10) begin
                case ($urandom_range(0, 3))
                    0: v = GPIO_ADDR_PINS0 + 4 * $urandom_range(0, 10);
                    1: v = MEM_SZ - 4 - $urandom_range(0, 8);
                    default: v = $urandom_range(256, 4096);
                endcase
            end
            // The value sits in the word after the load, which reads it as [pc, #-4].
            pc = shadow_regs[15];
            load_word(pc[15:0] + 16'd4, v);
            load_word(pc[15:0], {CC_AL, 8'b0101_0001, 4'd15, 4'(r), 12'd4});
            exec_one();
        end
    endtask

    task automatic test_host_access();
        load_word(16'h0000, 32'h0000_0000);
        load_word(16'hffff, 32'hdead_beef);
        send_item(ACT_MEM_RD, 16'hffff, 32'hffff_ffff, 4'hf);
        send_item(ACT_MEM_RD, 16'hfffe, 32'h0, 4'h0);
        load_word(16'h1000, 32'hffff_ffff);
        send_item(ACT_MEM_RD, 16'h1000, 32'h0, 4'h0);
        send_item(ACT_REG_RD, 16'h0, 32'h0, 4'd0);
        send_item(ACT_REG_RD, 16'h0, 32'h0, 4'd15);
        load_word(16'hffff, 32'h0);
    endtask

    task automatic test_directed_program();
        // MOV r1,#0xff ; MOVS r2,r1,LSL #24 ; CMP r1,r1 ; ADDEQ r3,r15,#1 ;
        // MUL r4,r1,r2 ; STR r1,[r0,#0x100] ; LDR r5,[r0],#4 ; a zero word
        // follows but is not executed, so later programs run on from there.
        logic [31:0] prog [8];
        prog = '{32'he3a010ff, 32'he1b02c01, 32'he1510001, 32'h028f3001,
                 32'he0040291, 32'he5801100, 32'he4905004, 32'h00000000};
        for (int i = 0; i < 8; i++) load_word(16'(i * 4), prog[i]);
        repeat (7) exec_one();
        for (int r = 0; r < 16; r++) send_item(ACT_REG_RD, 16'h0, 32'h0, 4'(r));
        wait_drained();
    endtask

    task automatic test_random_programs();
        // Once halted only reset recovers; keep programs out of halting mostly.
        while (n_items < 600) begin
            if (shadow_regs[15] > 16'h7000) rewind_pc();
            seed_regs();
            random_program($urandom_range(5, 25));
            send_item(ACT_REG_RD, 16'h0, 32'h0, 4'($urandom));
            send_item(ACT_MEM_RD, 16'($urandom_range(0, 8192)), 32'h0, 4'h0);
        end
    endtask

    task automatic test_halt();
        logic [31:0] pc;
        pc = shadow_regs[15];
        if (!shadow_halt && pc <= MEM_SZ - 4) begin
            load_word(pc[15:0], 32'h0);
            exec_one();
        end
        exec_one();
        send_item(ACT_REG_RD, 16'h0, 32'h0, 4'd15);
        wait_drained();
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata[37:0]);
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: %h", m_axis_tdata);
                n_fail++;
            end else begin
                want = expected_q.pop_front();
                n_results++;
                if (got.rdata !== want.rdata) begin
                    $error("read_data expected %h actual %h", want.rdata, got.rdata);
                    n_fail++;
                end
                if (got.halted !== want.halted) begin
                    $error("halted expected %b actual %b", want.halted, got.halted);
                    n_fail++;
                end
                if (got.done !== want.done) begin
                    $error("executed expected %b actual %b", want.done, got.done);
                    n_fail++;
                end
                if (got.gpio !== want.gpio) begin
                    $error("gpio_event expected %0d actual %0d", want.gpio, got.gpio);
                    n_fail++;
                end
                if (got.berr !== want.berr) begin
                    $error("bounds_error expected %b actual %b", want.berr, got.berr);
                    n_fail++;
                end
            end
        end
    end

    // Receiver: random stalls per item, or a long hold-off when asked.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        for (int i = 0; i < MEM_SZ; i++) shadow_mem[i] = 8'd0;
        for (int i = 0; i < 16; i++) shadow_regs[i] = '0;
        shadow_flags = '0;
        shadow_halt = 1'b0;
        exec_pc = '0;
        n_fail = 0;
        n_items = 0;
        n_results = 0;
        n_executed = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_host_access();
        test_directed_program();
        // Receiver holds off while the sender keeps offering items.
        hold_off = 1'b1;
        test_random_programs();
        test_halt();

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d items, %0d of them instruction steps; %0d results checked.",
                 n_items, n_executed, n_results);
        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("arm_subset_instruction_executor: match");
        end else begin
            $display("arm_subset_instruction_executor: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("arm_subset_instruction_executor: mismatch");
        $finish;
    end

endmodule
